### hdl/gdet_pkg.sv
// ----------------------------------------------------------------------------
// gdet_pkg: shared constants and helper functions for the determinant core
// Fixed-point constants, field widths and the size limit default.
// ----------------------------------------------------------------------------
package gdet_pkg;

   localparam int MAX_SIZE_DEFAULT = 8;
   localparam int ELEM_W  = 32;
   localparam int WORD_W  = 64;
   localparam int SIZE_W  = 4;

   localparam logic [WORD_W-1:0] Q_ONE = 64'h0000_0001_0000_0000;
   localparam logic [WORD_W-1:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] S_MIN = 64'h8000_0000_0000_0000;

   // Magnitude of a two's complement word
   function automatic logic [WORD_W-1:0] mag_of(input logic [WORD_W-1:0] x);
      return x[WORD_W-1] ? (~x + 64'd1) : x;
   endfunction

   // Signed result from magnitude, with saturation
   function automatic logic [WORD_W:0] from_mag(input logic [WORD_W-1:0] m,
                                                input logic neg);
      logic [WORD_W:0] r;
      if (neg) begin
         if (m > S_MIN) r = {1'b1, S_MIN};
         else           r = {1'b0, ~m + 64'd1};
      end else begin
         if (m > S_MAX) r = {1'b1, S_MAX};
         else           r = {1'b0, m};
      end
      return r;
   endfunction

endpackage

### hdl/gdet_ram.sv
// ----------------------------------------------------------------------------
// gdet_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gdet_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

### hdl/gdet_arith.sv
// ----------------------------------------------------------------------------
// gdet_arith: shared Q32.32 multiply / divide unit
// Multiply in four 32x32 partial products, one per cycle; divide by
// restoring long division, one quotient bit per cycle. Saturates on overflow.
// ----------------------------------------------------------------------------
module gdet_arith
   import gdet_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic              is_div,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   output logic              done,
   output logic [WORD_W-1:0] result,
   output logic              ovf
);
   typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_type;
   state_type state_ff;
   logic [6:0]   cnt_ff;
   logic         neg_ff, div_ff;
   logic [WORD_W-1:0] ma_ff, mb_ff, q_ff, lo_ff;
   logic [WORD_W:0]   r_ff;
   logic [127:0] acc_ff;
   logic         done_ff;
   logic [WORD_W-1:0] res_ff;
   logic         ovf_ff;

   logic [31:0] pa, pb;
   logic [63:0] pp;
   logic [WORD_W:0] r_sh;
   logic [WORD_W:0] fm;
   logic [WORD_W-1:0] qmag;
   logic [WORD_W-1:0] mag_a;

   assign mag_a = mag_of(op_a);

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: begin pa = ma_ff[31:0];  pb = mb_ff[31:0];  end
         2'd1: begin pa = ma_ff[31:0];  pb = mb_ff[63:32]; end
         2'd2: begin pa = ma_ff[63:32]; pb = mb_ff[31:0];  end
         default: begin pa = ma_ff[63:32]; pb = mb_ff[63:32]; end
      endcase
      pp = {32'd0, pa} * {32'd0, pb};
      r_sh = {r_ff[WORD_W-1:0], lo_ff[WORD_W-1]};
      if (div_ff) qmag = q_ff;
      else if (acc_ff[127:96] != 32'd0) qmag = '1;
      else qmag = acc_ff[95:32];
      fm = from_mag(qmag, neg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (go) begin
               neg_ff <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
               ma_ff  <= mag_a;
               mb_ff  <= mag_of(op_b);
               div_ff <= is_div;
               acc_ff <= '0;
               q_ff   <= '0;
               cnt_ff <= '0;
               r_ff   <= {33'd0, mag_a[63:32]};
               lo_ff  <= {mag_a[31:0], 32'd0};
               state_ff <= is_div ? S_DIV : S_MUL;
            end
            S_MUL: begin
               unique case (cnt_ff[1:0])
                  2'd0: acc_ff <= acc_ff + {64'd0, pp};
                  2'd1, 2'd2: acc_ff <= acc_ff + {32'd0, pp, 32'd0};
                  default: acc_ff <= acc_ff + {pp, 64'd0};
               endcase
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff[1:0] == 2'd3) state_ff <= S_FIN;
            end
            S_DIV: begin
               if (cnt_ff == 7'd0 && (mb_ff == '0 || r_ff[WORD_W-1:0] >= mb_ff)) begin
                  // zero divisor gives zero; too-large quotient saturates
                  if (mb_ff == '0) begin
                     res_ff <= '0; ovf_ff <= 1'b0; done_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     q_ff <= '1; cnt_ff <= 7'd64; state_ff <= S_FIN;
                  end
               end else begin
                  lo_ff <= lo_ff << 1;
                  q_ff  <= {q_ff[WORD_W-2:0], r_sh >= {1'b0, mb_ff}};
                  r_ff  <= (r_sh >= {1'b0, mb_ff}) ? r_sh - {1'b0, mb_ff} : r_sh;
                  cnt_ff <= cnt_ff + 7'd1;
                  if (cnt_ff == 7'd63) state_ff <= S_FIN;
               end
            end
            default: begin
               res_ff <= fm[WORD_W-1:0];
               ovf_ff <= fm[WORD_W];
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign result = res_ff;
   assign ovf = ovf_ff;
endmodule

### hdl/gauss_determinant_core.sv
// ----------------------------------------------------------------------------
// gauss_determinant_core: determinant by Gaussian elimination
// Loads an n-by-n Q16.16 matrix and returns its Q32.32 determinant.
// ----------------------------------------------------------------------------
// Usage: write n to csr_matrix_size while idle (0 acts as 1, above MAX_SIZE
// acts as MAX_SIZE; a write restarts loading). Pulse start with one element
// per item in row-major order; each accepted element holds busy high for one
// cycle. After element n*n-1 the core eliminates column by column on one
// shared multiply/divide unit and one storage RAM port. The result is shown
// for exactly one cycle with rsp_valid; the receiver cannot stall it, so
// capture it when the strobe is seen.
module gauss_determinant_core
   import gdet_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_matrix_element,
   input  logic                     csr_we,
   input  logic [SIZE_W-1:0]        csr_matrix_size,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] rsp_determinant,
   output logic                     rsp_singular,
   output logic                     rsp_overflow
);
   localparam int IW = $clog2(MAX_SIZE);
   localparam int AW = 2 * IW;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_PIV_RD, ST_PIV_WT, ST_PIV_CHK,
      ST_SRCH_RD, ST_SRCH_WT, ST_SRCH_CHK,
      ST_SW_RD1, ST_SW_RD2, ST_SW_WT, ST_SW_WR1, ST_SW_WR2,
      ST_F_RD, ST_F_WT, ST_F_DIV, ST_F_WAIT,
      ST_U_RD1, ST_U_RD2, ST_U_WT, ST_U_MUL, ST_U_WAIT, ST_U_WR,
      ST_P_MUL, ST_P_WAIT, ST_SIGN, ST_OUT
   } state_type;

   state_type state_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [IW:0] n_eff;
   logic [IW:0] row_ff, col_ff;     // load position
   logic [IW:0] i_ff, k_ff, j_ff, r_ff;
   logic [WORD_W-1:0] piv_ff, f_ff, t_ff, u_ff, prod_ff;
   logic sign_ff, ovf_ff, sing_ff;
   logic [WORD_W-1:0] det_ff;
   logic valid_ff;

   // storage port
   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   // arithmetic unit
   logic au_go, au_div, au_done, au_ovf;
   logic [WORD_W-1:0] au_a, au_b, au_res;

   function automatic logic [AW-1:0] addr_of(input logic [IW:0] r, input logic [IW:0] c);
      return {r[IW-1:0], c[IW-1:0]};
   endfunction

   always_comb begin
      if (size_ff == '0) n_eff = (IW+1)'(1);
      else if ({1'b0, size_ff} > (SIZE_W+1)'(MAX_SIZE)) n_eff = (IW+1)'(MAX_SIZE);
      else n_eff = (IW+1)'(size_ff);
   end

   gdet_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
      .clock, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   gdet_arith u_arith (
      .clock, .reset, .go(au_go), .is_div(au_div), .op_a(au_a), .op_b(au_b),
      .done(au_done), .result(au_res), .ovf(au_ovf)
   );

   // subtract with saturation, flag in top bit
   function automatic logic [WORD_W:0] sat_sub(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] d;
      d = a - b;
      if ((a[WORD_W-1] ^ b[WORD_W-1]) && (a[WORD_W-1] ^ d[WORD_W-1]))
         return {1'b1, a[WORD_W-1] ? S_MIN : S_MAX};
      return {1'b0, d};
   endfunction

   logic [WORD_W:0] sub_res, neg_res;
   assign sub_res = sat_sub(u_ff, au_res);
   assign neg_res = sat_sub('0, prod_ff);

   // drive storage port and arithmetic unit from the sequencer; hold the read
   // address through each wait state so the data stays put for its user
   always_comb begin
      ram_we = 1'b0;
      ram_addr = addr_of(i_ff, i_ff);
      ram_wdata = '0;
      au_go = 1'b0;
      au_div = 1'b0;
      au_a = prod_ff;
      au_b = piv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_addr = addr_of(row_ff, col_ff);
            ram_wdata = {{(WORD_W-ELEM_W-16){req_matrix_element[ELEM_W-1]}},
                         req_matrix_element, 16'd0};
            ram_we = start;
         end
         ST_SRCH_RD, ST_SRCH_WT: ram_addr = addr_of(r_ff, i_ff);
         ST_SW_RD1:  ram_addr = addr_of(i_ff, j_ff);
         ST_SW_RD2, ST_SW_WT: ram_addr = addr_of(r_ff, j_ff);
         ST_SW_WR1: begin
            ram_addr = addr_of(i_ff, j_ff); ram_wdata = ram_rdata; ram_we = 1'b1;
         end
         ST_SW_WR2: begin
            ram_addr = addr_of(r_ff, j_ff); ram_wdata = t_ff; ram_we = 1'b1;
         end
         ST_F_RD, ST_F_WT: ram_addr = addr_of(k_ff, i_ff);
         ST_F_DIV: begin au_go = 1'b1; au_div = 1'b1; au_a = ram_rdata; end
         ST_U_RD1: ram_addr = addr_of(i_ff, j_ff);
         ST_U_RD2, ST_U_WT: ram_addr = addr_of(k_ff, j_ff);
         ST_U_MUL: begin au_go = 1'b1; au_a = t_ff; au_b = f_ff; end
         ST_U_WR: begin
            ram_addr = addr_of(k_ff, j_ff); ram_wdata = sub_res[WORD_W-1:0];
            ram_we = 1'b1;
         end
         ST_P_MUL: begin au_go = 1'b1; au_a = prod_ff; au_b = piv_ff; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= SIZE_W'(8);
         row_ff   <= '0;
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_we) begin
            // restart loading on any size write
            size_ff <= csr_matrix_size;
            row_ff  <= '0;
            col_ff  <= '0;
         end
         unique case (state_ff)
            ST_IDLE: if (start && !csr_we) begin
               if (row_ff >= n_eff) begin
                  row_ff <= '0; col_ff <= '0;  // stale position, restart
               end
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               // advance the load position; run elimination after the last
               if (col_ff + 1'b1 >= n_eff) begin
                  col_ff <= '0;
                  if (row_ff + 1'b1 >= n_eff) begin
                     row_ff <= '0;
                     i_ff <= '0; prod_ff <= Q_ONE; sign_ff <= 1'b0;
                     ovf_ff <= 1'b0; sing_ff <= 1'b0;
                     state_ff <= ST_PIV_RD;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_PIV_RD: state_ff <= ST_PIV_WT;
            ST_PIV_WT: state_ff <= ST_PIV_CHK;
            ST_PIV_CHK: begin
               piv_ff <= ram_rdata;
               if (ram_rdata == '0) begin
                  r_ff <= i_ff + 1'b1;
                  state_ff <= ST_SRCH_RD;
               end else begin
                  k_ff <= i_ff + 1'b1;
                  state_ff <= ST_F_RD;
               end
            end
            ST_SRCH_RD: begin
               if (r_ff >= n_eff) begin
                  sing_ff <= 1'b1; det_ff <= '0;
                  state_ff <= ST_OUT;
               end else state_ff <= ST_SRCH_WT;
            end
            ST_SRCH_WT: state_ff <= ST_SRCH_CHK;
            ST_SRCH_CHK: begin
               if (ram_rdata != '0) begin
                  j_ff <= '0; sign_ff <= ~sign_ff;
                  state_ff <= ST_SW_RD1;
               end else begin
                  r_ff <= r_ff + 1'b1;
                  state_ff <= ST_SRCH_RD;
               end
            end
            ST_SW_RD1: state_ff <= ST_SW_RD2;
            ST_SW_RD2: begin t_ff <= ram_rdata; state_ff <= ST_SW_WT; end
            ST_SW_WT: state_ff <= ST_SW_WR1;
            ST_SW_WR1: state_ff <= ST_SW_WR2;
            ST_SW_WR2: begin
               if (j_ff + 1'b1 >= n_eff) state_ff <= ST_PIV_RD;
               else begin j_ff <= j_ff + 1'b1; state_ff <= ST_SW_RD1; end
            end
            ST_F_RD: begin
               if (k_ff >= n_eff) state_ff <= ST_P_MUL;
               else state_ff <= ST_F_WT;
            end
            ST_F_WT: state_ff <= ST_F_DIV;
            ST_F_DIV: state_ff <= ST_F_WAIT;
            ST_F_WAIT: if (au_done) begin
               f_ff <= au_res; ovf_ff <= ovf_ff | au_ovf;
               j_ff <= i_ff + 1'b1;
               state_ff <= ST_U_RD1;
            end
            ST_U_RD1: begin
               if (j_ff >= n_eff) begin
                  k_ff <= k_ff + 1'b1;
                  state_ff <= ST_F_RD;
               end else state_ff <= ST_U_RD2;
            end
            ST_U_RD2: begin t_ff <= ram_rdata; state_ff <= ST_U_WT; end
            ST_U_WT: begin state_ff <= ST_U_MUL; end
            ST_U_MUL: begin u_ff <= ram_rdata; state_ff <= ST_U_WAIT; end
            ST_U_WAIT: if (au_done) begin
               ovf_ff <= ovf_ff | au_ovf;
               state_ff <= ST_U_WR;
            end
            ST_U_WR: begin
               ovf_ff <= ovf_ff | sub_res[WORD_W];
               j_ff <= j_ff + 1'b1;
               state_ff <= ST_U_RD1;
            end
            ST_P_MUL: state_ff <= ST_P_WAIT;
            ST_P_WAIT: if (au_done) begin
               prod_ff <= au_res; ovf_ff <= ovf_ff | au_ovf;
               if (i_ff + 1'b1 >= n_eff) state_ff <= ST_SIGN;
               else begin i_ff <= i_ff + 1'b1; state_ff <= ST_PIV_RD; end
            end
            ST_SIGN: begin
               if (sign_ff) begin
                  det_ff <= neg_res[WORD_W-1:0];
                  ovf_ff <= ovf_ff | neg_res[WORD_W];
               end else det_ff <= prod_ff;
               state_ff <= ST_OUT;
            end
            default: begin
               valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // the row index register drives the ST_U_RD1 read of the pivot row; the
   // element at column i of row k is left stale since its value never enters the arithmetic again
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_determinant = det_ff;
   assign rsp_singular = sing_ff;
   assign rsp_overflow = ovf_ff;
endmodule
